// File: rtl/core/crc24w_pkg.sv
// Package for the CRC-24 word-pair engine: widths, polynomial and the word update.
// No dependencies; used by crc24w_out_buf.sv and crc24_word_pair_engine.sv.
package crc24w_pkg;

    localparam int unsigned CRC_W  = 24;
    localparam int unsigned BYTE_W = 8;

    typedef logic [CRC_W-1:0]  crc_t;
    typedef logic [BYTE_W-1:0] byte_t;

    // Generator polynomial without the implicit bit 24.
    localparam crc_t CRC_POLY = 24'h80001B;

    // One word step: shift left, XOR the little-endian word in, reduce on bit 24.
    function automatic crc_t word_update(crc_t crc, byte_t lo, byte_t hi);
        logic [CRC_W:0] t;
        t = {crc, 1'b0} ^ {{(CRC_W + 1 - 2 * BYTE_W){1'b0}}, hi, lo};
        if (t[CRC_W])
        begin
            t[CRC_W-1:0] = t[CRC_W-1:0] ^ CRC_POLY;
        end
        return t[CRC_W-1:0];
    endfunction

endpackage

// File: rtl/core/crc24w_out_buf.sv
// Result buffer for the CRC-24 engine: an output register backed by one skid entry.
// Depends on crc24w_pkg for the CRC type.
module crc24w_out_buf
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  crc24w_pkg::crc_t   push_data,
    output logic               room,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [23:0]        m_tdata    // crc_value[23:0]
);

    logic             out_valid_reg, out_valid_next;
    crc24w_pkg::crc_t out_data_reg,  out_data_next;
    logic             skid_valid_reg, skid_valid_next;
    crc24w_pkg::crc_t skid_data_reg,  skid_data_next;
    logic             pop;

    assign pop      = out_valid_reg && m_tready;
    assign room     = !skid_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = push;
                skid_data_next  = push_data;
            end
            else
            begin
                out_valid_next = push;
                out_data_next  = push_data;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

// File: rtl/core/crc24_word_pair_engine.sv
// Top level of the CRC-24 word-pair engine: byte input, running CRC, result output.
// Depends on crc24w_pkg and crc24w_out_buf.
//
// The engine computes a 24-bit CRC (polynomial 0x80001B) over a message fed one
// byte per beat on the slave stream. Bytes are paired little-endian into 16-bit
// words; each word shifts the CRC left by one, is XORed in, and reduces on bit 24.
// s_tuser marks the first byte of a message (the CRC is loaded from the seed
// register and any held byte is dropped); s_tlast marks the last byte, after which
// a lone last byte is paired with a zero high byte and the CRC is sent on the
// master stream. A message without a first mark continues from the CRC left by the
// previous one. Each byte is folded into the state registers at the edge that
// accepts it, through at most one word update, so a new byte is accepted in every
// cycle while s_tready is high. Results pass through an output register with a
// one-entry skid stage, so input stalls only when two results wait downstream.
// Write the seed register via seed_wr_en/seed_wr_data only while idle (not enforced).
module crc24_word_pair_engine
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        seed_wr_en,
    input  logic [23:0] seed_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,      // data_byte[7:0]
    input  logic        s_tuser,      // first_byte
    input  logic        s_tlast,      // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata       // crc_value[23:0]
);

    crc24w_pkg::crc_t  seed_reg;
    crc24w_pkg::crc_t  crc_reg, crc_next;
    crc24w_pkg::byte_t pend_byte_reg, pend_byte_next;
    logic              pend_valid_reg, pend_valid_next;

    logic              accept;
    logic              room;
    crc24w_pkg::crc_t  base_crc;
    logic              base_pend;
    crc24w_pkg::byte_t upd_lo;
    crc24w_pkg::byte_t upd_hi;
    crc24w_pkg::crc_t  upd_crc;
    logic              do_update;

    assign s_tready = room;
    assign accept   = s_tvalid && s_tready;

    // A first mark restarts from the seed with nothing held.
    assign base_crc  = s_tuser ? seed_reg : crc_reg;
    assign base_pend = s_tuser ? 1'b0 : pend_valid_reg;

    // At most one word update per byte: either this byte completes a held pair,
    // or it is a lone last byte paired with zero.
    assign do_update = base_pend || s_tlast;
    assign upd_lo    = base_pend ? pend_byte_reg : s_tdata;
    assign upd_hi    = base_pend ? s_tdata : '0;
    assign upd_crc   = crc24w_pkg::word_update(base_crc, upd_lo, upd_hi);

    always_comb
    begin
        crc_next        = crc_reg;
        pend_byte_next  = pend_byte_reg;
        pend_valid_next = pend_valid_reg;
        if (accept)
        begin
            crc_next        = do_update ? upd_crc : base_crc;
            pend_valid_next = !do_update;
            pend_byte_next  = do_update ? '0 : s_tdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg       <= '0;
            crc_reg        <= '0;
            pend_byte_reg  <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            if (seed_wr_en)
            begin
                seed_reg <= seed_wr_data;
            end
            crc_reg        <= crc_next;
            pend_byte_reg  <= pend_byte_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    crc24w_out_buf u_out_buf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept && s_tlast),
        .push_data (crc_next),
        .room      (room),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // A last byte always leaves a result waiting and nothing held.
    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_tlast) |=> (m_tvalid && !pend_valid_reg))
        else $error("last byte did not produce a result");

    // A first byte that is not also last is held as the low half of a word.
    a_first_holds_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_tuser && !s_tlast) |=> (pend_valid_reg && pend_byte_reg == $past(s_tdata)))
        else $error("first byte not held as pending low byte");

    // A byte that completes a pair leaves nothing held.
    a_pair_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !s_tuser && pend_valid_reg) |=> !pend_valid_reg)
        else $error("pending byte survived its pair");

    // Input stalls only while the output side holds a waiting result.
    a_stall_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with empty output");

    // Without a byte accepted the running state stays put.
    a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> ($stable(crc_reg) && $stable(pend_valid_reg)))
        else $error("CRC state changed without an accepted byte");

endmodule
